/* hdl/fpop_pkg.sv */
// Package for the Feistel pixel-order permuter: screen geometry, widths and the round function.
`default_nettype none
package fpop_pkg;

  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 200;
  localparam int unsigned ROUND_COUNT   = 4;

  localparam int unsigned STEP_W  = 16;
  localparam int unsigned HALF_W  = 8;
  localparam int unsigned X_W     = 9;
  localparam int unsigned Y_W     = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_W-1:0] ROUND_OFFSET_RESET     = 16'd123;
  localparam logic [CFG_W-1:0] ROUND_MULTIPLIER_RESET = 16'd42871;

  // Number of on-screen positions, held in 33 bits.
  localparam logic [32:0] PIXEL_LIMIT = 33'(64'(SCREEN_WIDTH) * 64'(SCREEN_HEIGHT));

  // Reciprocal of the width; the quotient it gives is exact or one short.
  localparam logic [31:0] DIV_RECIP = 32'(64'hFFFF_FFFF / 64'(SCREEN_WIDTH));
  localparam logic [15:0] WIDTH_C   = 16'(SCREEN_WIDTH);
  localparam logic [16:0] WIDTH_X   = 17'(SCREEN_WIDTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROUND_OFFSET     = 8'd0,
    REG_ROUND_MULTIPLIER = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic              valid;
    logic [HALF_W-1:0] left;
    logic [HALF_W-1:0] right;
  } round_stage_t;

  // Only the low byte of the product is kept, so only the low bytes of the
  // operands matter.
  function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] half,
                                                 input logic [HALF_W-1:0] offset,
                                                 input logic [HALF_W-1:0] mult);
    logic [HALF_W-1:0]   sum;
    logic [2*HALF_W-1:0] prod;
    sum  = half + offset;
    prod = (2*HALF_W)'(sum) * (2*HALF_W)'(mult);
    return prod[HALF_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/feistel_pixel_order_permuter.sv */
// Top level: pipelined Feistel permutation of a step index into a screen column and row.
// From start to the result strobe there is one register stage per Feistel round, then three
// stages for the divide by the width.
// Throughput is one item per cycle; busy never rises and the receiver cannot stall.
// Reset clears all valid bits and loads the round registers with the low bytes of their reset values;
// no result is strobed until an item has passed through the whole pipeline.
`default_nettype none
module feistel_pixel_order_permuter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [fpop_pkg::STEP_W-1:0]     step_index_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [fpop_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fpop_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                                 out_valid_o,
  output logic [fpop_pkg::X_W-1:0]             pixel_x_o,
  output logic [fpop_pkg::Y_W-1:0]             pixel_y_o,
  output logic                                 on_screen_o
);
  import fpop_pkg::*;

  logic [HALF_W-1:0] offset_q;
  logic [HALF_W-1:0] mult_q;

  // Stage r holds the halves after round r + 1.
  round_stage_t stage_q [ROUND_COUNT];

  logic              d1_valid_q, d1_on_q;
  logic [15:0]       d1_pos_q, d1_quot_q;
  logic [47:0]       d1_prod;

  logic              d2_valid_q, d2_on_q;
  logic [15:0]       d2_quot_q;
  logic [16:0]       d2_rem_q;
  logic [31:0]       d2_prod;
  logic [16:0]       d2_rem_d;

  logic              out_valid_q, on_screen_q;
  logic [X_W-1:0]    pixel_x_q, pixel_x_d;
  logic [Y_W-1:0]    pixel_y_q, pixel_y_d;
  logic [15:0]       quot_fix;
  logic [16:0]       rem_fix;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Only the low byte of each round register reaches the round function.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= ROUND_OFFSET_RESET[HALF_W-1:0];
      mult_q   <= ROUND_MULTIPLIER_RESET[HALF_W-1:0];
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROUND_OFFSET:     offset_q <= cfg_data_i[HALF_W-1:0];
        REG_ROUND_MULTIPLIER: mult_q   <= cfg_data_i[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q[0] <= '0;
    end else begin
      stage_q[0] <= {start && !busy, step_index_i[HALF_W-1:0],
                     step_index_i[STEP_W-1:HALF_W]
                     ^ round_fn(step_index_i[HALF_W-1:0], offset_q, mult_q)};
    end
  end

  for (genvar r = 1; r < ROUND_COUNT; r++) begin : g_round
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stage_q[r] <= '0;
      end else begin
        stage_q[r] <= {stage_q[r-1].valid, stage_q[r-1].right,
                       stage_q[r-1].left ^ round_fn(stage_q[r-1].right, offset_q, mult_q)};
      end
    end
  end

  // Divide stage one: bounds test and the reciprocal estimate of the quotient.
  assign d1_prod = 48'({stage_q[ROUND_COUNT-1].left, stage_q[ROUND_COUNT-1].right})
                   * 48'(DIV_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_valid_q <= 1'b0;
    end else begin
      d1_valid_q <= stage_q[ROUND_COUNT-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_pos_q  <= {stage_q[ROUND_COUNT-1].left, stage_q[ROUND_COUNT-1].right};
    d1_quot_q <= d1_prod[47:32];
    d1_on_q   <= {17'd0, stage_q[ROUND_COUNT-1].left, stage_q[ROUND_COUNT-1].right}
                 < PIXEL_LIMIT;
  end

  // Divide stage two: remainder of the estimate, which lies below twice the width.
  assign d2_prod  = 32'(d1_quot_q) * 32'(WIDTH_C);
  assign d2_rem_d = {1'b0, d1_pos_q} - d2_prod[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d2_valid_q <= 1'b0;
    end else begin
      d2_valid_q <= d1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_quot_q <= d1_quot_q;
    d2_rem_q  <= d2_rem_d;
    d2_on_q   <= d1_on_q;
  end

  // Divide stage three: one correction step, then masking to the field widths; off-screen positions give zeros.
  always_comb begin
    if (d2_rem_q >= WIDTH_X) begin
      quot_fix = d2_quot_q + 16'd1;
      rem_fix  = d2_rem_q - WIDTH_X;
    end else begin
      quot_fix = d2_quot_q;
      rem_fix  = d2_rem_q;
    end
    if (d2_on_q) begin
      pixel_x_d = rem_fix[X_W-1:0];
      pixel_y_d = quot_fix[Y_W-1:0];
    end else begin
      pixel_x_d = '0;
      pixel_y_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= d2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_x_q   <= pixel_x_d;
    pixel_y_q   <= pixel_y_d;
    on_screen_q <= d2_on_q;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = pixel_x_q;
  assign pixel_y_o   = pixel_y_q;
  assign on_screen_o = on_screen_q;

endmodule
`default_nettype wire
